// ===== design/ccf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_pkg: shared types and constants of the character counting credit unit
// Beat formats, command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ccf_pkg;

   localparam int LEN_W       = 10;
   localparam int STATUS_W    = 3;
   localparam int LINES_W     = 7;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 64;

   localparam logic [LEN_W-1:0] CREDIT_MAX   = 10'd1023;
   localparam logic [LEN_W-1:0] CAP_RESET    = 10'd128;

   localparam logic [CMD_W-1:0] CMD_SEND     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SOFT_RST = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_WAIT      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_HALTED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ACK_EMPTY = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RST_DONE  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALT            = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_UP         = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [LEN_W-1:0] line_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    credit_left;
      logic [LINES_W-1:0]  lines_outstanding;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] buffer_capacity;
      logic             halt;
      logic             link_up;
   } cfg_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// ===== design/ccf_len_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_len_ram: line length queue storage
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ccf_len_ram #(
   parameter int DEPTH = ccf_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ccf_pkg::LEN_W-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [ccf_pkg::LEN_W-1:0]    rd_data
);

   logic [ccf_pkg::LEN_W-1:0] mem [DEPTH];
   logic [ccf_pkg::LEN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ccf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_ctrl: credit and queue control
// Holds the free credit and queue pointers, executes one command per item
// against the length memory and drives the result register.
// ----------------------------------------------------------------------------
module ccf_ctrl #(
   parameter int QUEUE_DEPTH = ccf_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ccf_pkg::cfg_type                 cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ccf_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ccf_pkg::rsp_type                 rsp_data,
   output logic                             mem_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_wr_addr,
   output logic [ccf_pkg::LEN_W-1:0]        mem_wr_data,
   output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_rd_addr,
   input  logic [ccf_pkg::LEN_W-1:0]        mem_rd_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   ccf_pkg::state_type state_ff, state_in;
   ccf_pkg::req_type   item_ff, item_in;
   ccf_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ccf_pkg::LEN_W-1:0] credit_ff, credit_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic                        exec_go;
   logic [ccf_pkg::LEN_W:0]     credit_sum;
   logic [CNT_W+ccf_pkg::LINES_W-1:0] count_wide;
   logic [ccf_pkg::STATUS_W-1:0] status;

   assign exec_go = (state_ff == ccf_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ccf_pkg::ST_EXEC;
            end
         end
         ccf_pkg::ST_EXEC: begin
            if (exec_go) begin
               state_in = ccf_pkg::ST_IDLE;
            end
         end
         default: state_in = ccf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ccf_pkg::ST_IDLE);
      item_in      = (req_valid && req_ready) ? req_data : item_ff;
      credit_in    = credit_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      mem_wr_en    = 1'b0;
      status       = ccf_pkg::STATUS_WAIT;
      credit_sum   = {1'b0, credit_ff} + {1'b0, mem_rd_data};
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (exec_go) begin
         unique case (item_ff.cmd)
            ccf_pkg::CMD_SEND: begin
               if (cfg.halt) begin
                  status = ccf_pkg::STATUS_HALTED;
               end else if (cfg.link_up && (item_ff.line_length <= credit_ff) &&
                            (count_ff != FULL_CNT)) begin
                  credit_in = credit_ff - item_ff.line_length;
                  mem_wr_en = 1'b1;
                  tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);
                  count_in  = count_ff + CNT_W'(1);
                  status    = ccf_pkg::STATUS_ACCEPTED;
               end
            end
            ccf_pkg::CMD_ACK: begin
               if (count_ff == '0) begin
                  status = ccf_pkg::STATUS_ACK_EMPTY;
               end else begin
                  credit_in = credit_sum[ccf_pkg::LEN_W] ? ccf_pkg::CREDIT_MAX
                                                         : credit_sum[ccf_pkg::LEN_W-1:0];
                  head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
                  count_in  = count_ff - CNT_W'(1);
                  status    = ccf_pkg::STATUS_ACCEPTED;
               end
            end
            ccf_pkg::CMD_SOFT_RST: begin
               credit_in = cfg.buffer_capacity;
               head_in   = '0;
               tail_in   = '0;
               count_in  = '0;
               status    = ccf_pkg::STATUS_RST_DONE;
            end
            default: status = ccf_pkg::STATUS_WAIT;
         endcase
         rsp_valid_in = 1'b1;
      end
      count_wide = {{ccf_pkg::LINES_W{1'b0}}, count_in};
      if (exec_go) begin
         rsp_in.status            = status;
         rsp_in.credit_left       = credit_in;
         rsp_in.lines_outstanding = count_wide[ccf_pkg::LINES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         credit_ff    <= ccf_pkg::CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         credit_ff    <= credit_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign mem_wr_addr = tail_ff;
   assign mem_wr_data = item_ff.line_length;
   assign mem_rd_addr = head_ff;

endmodule

// ===== design/char_count_credit_flow_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_count_credit_flow_unit: sender-side character credit tracker
// Tracks free receiver buffer credit and queues the lengths of unacknowledged
// lines in an on-chip memory.
// ----------------------------------------------------------------------------
// Each request beat is answered by a response beat once its command executes:
// the accepting edge loads the registered read of the length memory at the
// queue head, and the execute edge, taken once the response register is free,
// executes the command, writes back and loads the response register. The next
// request can be accepted at the edge after the execute edge, so a request is
// not taken while the previous one still waits to execute. The response
// register lets a finished beat wait while the next request is accepted; that
// request then executes once the waiting beat is taken. The length memory needs
// no clearing after reset. Configuration writes are always accepted.
module char_count_credit_flow_unit #(
   parameter int QUEUE_DEPTH = ccf_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ccf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ccf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ccf_pkg::LEN_W-1:0]         csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   ccf_pkg::cfg_type cfg_ff, cfg_in;

   logic                      mem_wr_en;
   logic [PTR_W-1:0]          mem_wr_addr;
   logic [ccf_pkg::LEN_W-1:0] mem_wr_data;
   logic [PTR_W-1:0]          mem_rd_addr;
   logic [ccf_pkg::LEN_W-1:0] mem_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ccf_pkg::CSR_BUFFER_CAPACITY: cfg_in.buffer_capacity = csr_wdata;
            ccf_pkg::CSR_HALT:            cfg_in.halt            = csr_wdata[0];
            ccf_pkg::CSR_LINK_UP:         cfg_in.link_up         = csr_wdata[0];
            default:                      cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_capacity <= ccf_pkg::CAP_RESET;
         cfg_ff.halt            <= 1'b0;
         cfg_ff.link_up         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccf_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ccf_len_ram #(
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== design/ccf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_checker: port-level checks for the credit tracker
// Watches the request and response channels over time and is bound to the
// top level.
// ----------------------------------------------------------------------------
module ccf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ccf_pkg::rsp_type rsp_data
);

   // A waiting response beat must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed or dropped while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Requests are executed one at a time, so two accepts never follow directly.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one executes");

   // An empty acknowledge and a soft reset both report an empty queue.
   a_empty_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ccf_pkg::STATUS_ACK_EMPTY ||
                    rsp_data.status == ccf_pkg::STATUS_RST_DONE)
      |-> rsp_data.lines_outstanding == '0)
      else $error("queue not empty on empty acknowledge or soft reset");

endmodule

bind char_count_credit_flow_unit ccf_checker u_ccf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/credit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_checker: response checker for the character credit unit
// Follows every request, response and register write beat. It keeps its own
// copy of the credit, the outstanding line lengths and the registers. It
// compares each response beat with the oldest predicted report.
// ----------------------------------------------------------------------------
module credit_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  ccf_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ccf_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ccf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccf_pkg::LEN_W-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            reports_due
);
   import ccf_pkg::*;

   localparam int PRINT_LIMIT = 60;

   logic [LEN_W-1:0] capacity    = CAP_RESET;
   logic             halt_on     = 1'b0;
   logic             link_on     = 1'b0;
   logic [LEN_W-1:0] free_credit = CAP_RESET;
   logic [LEN_W-1:0] line_lens[$];
   rsp_type          due_reports[$];
   int               errors      = 0;

   initial begin
      mismatch_count = 0;
      reports_due    = 0;
   end

   function automatic rsp_type track_credit(input req_type item);
      rsp_type     report;
      logic [LEN_W:0] sum;
      report.status = STATUS_WAIT;
      case (item.cmd)
         CMD_SEND: begin
            if (halt_on) begin
               report.status = STATUS_HALTED;
            end else if (link_on && item.line_length <= free_credit &&
                         line_lens.size() < QUEUE_DEPTH) begin
               free_credit = free_credit - item.line_length;
               line_lens.push_back(item.line_length);
               report.status = STATUS_ACCEPTED;
            end
         end
         CMD_ACK: begin
            if (line_lens.size() == 0) begin
               report.status = STATUS_ACK_EMPTY;
            end else begin
               sum = {1'b0, free_credit} + {1'b0, line_lens.pop_front()};
               free_credit = (sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : sum[LEN_W-1:0];
               report.status = STATUS_ACCEPTED;
            end
         end
         CMD_SOFT_RST: begin
            line_lens.delete();
            free_credit = capacity;
            report.status = STATUS_RST_DONE;
         end
         default: begin
         end
      endcase
      report.credit_left       = free_credit;
      report.lines_outstanding = LINES_W'(line_lens.size());
      return report;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         if (errors < PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         capacity    = CAP_RESET;
         halt_on     = 1'b0;
         link_on     = 1'b0;
         free_credit = CAP_RESET;
         line_lens.delete();
         due_reports.delete();
      end else begin
         if (req_valid && req_ready)
            due_reports.push_back(track_credit(req_data));
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               if (errors < PRINT_LIMIT)
                  $display("%0t: unexpected response beat, expected none, actual %h",
                           $time, rsp_data);
               errors++;
            end else begin
               want = due_reports.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_data.status));
               check_field("credit_left", 16'(want.credit_left), 16'(rsp_data.credit_left));
               check_field("lines_outstanding", 16'(want.lines_outstanding),
                           16'(rsp_data.lines_outstanding));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BUFFER_CAPACITY: capacity = csr_wdata;
               CSR_HALT:            halt_on  = csr_wdata[0];
               CSR_LINK_UP:         link_on  = csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      mismatch_count <= errors;
      reports_due    <= due_reports.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the character credit unit
// A directed sequence covers link down, halt, full credit, zero capacity and
// empty acknowledges. Random phases follow. Each phase applies its own register
// settings, command mix and choice of stalls on both sides. A watchdog ends a hung run.
// ----------------------------------------------------------------------------
module testbench;
   import ccf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1000;
   localparam int QUIET_TAIL  = 100;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {
      MIX_BALANCED,
      MIX_FILL,
      MIX_DRAIN
   } mix_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0]     csr_wdata = '0;

   int          mismatch_count;
   int          reports_due;
   int          sent        = 0;
   bit          quiet       = 1'b0;
   bit          gaps_on     = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned idle_cycles = 0;

   always #6 clock = ~clock;

   char_count_credit_flow_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   credit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .reports_due    (reports_due)
   );

   always @(posedge clock) begin
      if (reset || quiet || !gaps_on) begin
         rsp_ready <= 1'b1;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= 1'($urandom_range(0, 1));
         hold_left <= $urandom_range(0, 13);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len);
      req_data  <= '{cmd: cmd, line_length: len};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic pace();
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [LEN_W-1:0] cap, input bit halt_bit,
                                 input bit link_bit);
      write_csr(CSR_BUFFER_CAPACITY, cap);
      write_csr(CSR_HALT, LEN_W'(halt_bit));
      write_csr(CSR_LINK_UP, LEN_W'(link_bit));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type pick_line(input mix_type mode);
      req_type     item;
      int unsigned roll;
      int unsigned send_pct;
      case ($urandom_range(0, 9))
         0:          item.line_length = CREDIT_MAX;
         1:          item.line_length = '0;
         2, 3, 4, 5: item.line_length = LEN_W'($urandom_range(0, 15));
         default:    item.line_length = LEN_W'($urandom);
      endcase
      case (mode)
         MIX_FILL:  send_pct = 85;
         MIX_DRAIN: send_pct = 25;
         default:   send_pct = 55;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < send_pct)
         item.cmd = CMD_SEND;
      else if (roll < 96)
         item.cmd = CMD_ACK;
      else if (roll < 98)
         item.cmd = CMD_SOFT_RST;
      else
         item.cmd = CMD_UNUSED;
      return item;
   endfunction

   initial begin
      int               count;
      req_type          item;
      logic [LEN_W-1:0] cap;
      bit               halt_bit;
      bit               link_bit;
      mix_type          mode;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers still hold their reset values, so the link is down.
      send_req(CMD_SEND, 10'd5);
      send_req(CMD_ACK, 10'd0);
      send_req(CMD_UNUSED, 10'd0);
      send_req(CMD_SOFT_RST, 10'd0);
      settle();
      apply_settings(CAP_RESET, 1'b0, 1'b1);
      send_req(CMD_SEND, 10'd0);
      send_req(CMD_SEND, 10'd100);
      send_req(CMD_SEND, 10'd29);
      send_req(CMD_SEND, 10'd28);
      send_req(CMD_SEND, 10'd0);
      repeat (5) send_req(CMD_ACK, 10'd0);
      settle();
      apply_settings(CREDIT_MAX, 1'b1, 1'b0);
      send_req(CMD_SEND, CREDIT_MAX);
      send_req(CMD_SOFT_RST, 10'd0);
      send_req(CMD_ACK, 10'd0);
      settle();
      apply_settings(CREDIT_MAX, 1'b0, 1'b1);
      send_req(CMD_SEND, CREDIT_MAX);
      send_req(CMD_SEND, 10'd1);
      send_req(CMD_ACK, 10'd0);
      settle();
      apply_settings('0, 1'b0, 1'b1);
      send_req(CMD_SOFT_RST, CREDIT_MAX);
      send_req(CMD_SEND, 10'd0);
      send_req(CMD_SEND, 10'd1);
      send_req(CMD_ACK, 10'd0);

      while (sent < ITEM_TARGET) begin
         settle();
         case ($urandom_range(0, 9))
            0:       cap = '0;
            1:       cap = 10'd1;
            2, 3:    cap = LEN_W'($urandom);
            default: cap = CREDIT_MAX;
         endcase
         halt_bit = ($urandom_range(0, 7) == 0);
         link_bit = ($urandom_range(0, 7) != 0);
         apply_settings(cap, halt_bit, link_bit);
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 2))
            0:       mode = MIX_FILL;
            1:       mode = MIX_DRAIN;
            default: mode = MIX_BALANCED;
         endcase
         send_req(CMD_SOFT_RST, LEN_W'($urandom));
         pace();
         count = $urandom_range(20, 80);
         repeat (count) begin
            if (sent >= ITEM_TARGET - QUIET_TAIL)
               quiet = 1'b1;
            item = pick_line(mode);
            send_req(item.cmd, item.line_length);
            pace();
         end
      end

      quiet = 1'b1;
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
